// ----- rtl/fccl_pkg.sv -----
// Shared constants and types for the FAT cluster chain locator.
package fccl_pkg;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Per-item divider: quotient bits resolved per pipeline stage.
    localparam int DIV_W          = 32;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = DIV_W / BITS_PER_STAGE;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BPS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COPIES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FATSZ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOFF   = 3'd7;

    // Register reset values.
    localparam logic [12:0] RST_BPS    = 13'd512;
    localparam logic [7:0]  RST_SPC    = 8'd1;
    localparam logic [15:0] RST_RESV   = 16'd1;
    localparam logic [7:0]  RST_COPIES = 8'd2;
    localparam logic [15:0] RST_ROOT   = 16'd512;
    localparam logic [31:0] RST_FATSZ  = 32'd9;
    localparam logic [31:0] RST_TOTAL  = 32'd2880;
    localparam logic [31:0] RST_VOFF   = 32'd0;

    // Request modes.
    localparam logic [1:0] MODE_LOCATE = 2'd0;
    localparam logic [1:0] MODE_DECODE = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;

    // FAT types.
    localparam logic [1:0] TYPE_FAT12 = 2'd0;
    localparam logic [1:0] TYPE_FAT16 = 2'd1;
    localparam logic [1:0] TYPE_FAT32 = 2'd2;

    // Type thresholds and end or bad marks.
    localparam logic [31:0] LIM_FAT12  = 32'h0000_0FF5;
    localparam logic [31:0] LIM_FAT16  = 32'h0000_FFF5;
    localparam logic [27:0] MARK_FAT12 = 28'h000_0FF7;
    localparam logic [27:0] MARK_FAT16 = 28'h000_FFF7;
    localparam logic [27:0] MARK_FAT32 = 28'hFFF_FFF7;
    localparam logic [11:0] MASK12     = 12'hFFF;
    localparam logic [27:0] MASK28     = 28'hFFF_FFFF;

    typedef struct packed {
        logic        vld;
        logic [1:0]  mode;
        logic [27:0] cluster;
        logic [31:0] raw;
        logic        oor;
        logic [31:0] prod;
        logic [31:0] dvd;
        logic [12:0] rem;
    } t_pipe;

endpackage

// ----- rtl/fat_cluster_chain_locator.sv -----
// FAT cluster chain locator: geometry derivation and pipelined cluster lookups.
// One item per cycle sustained while m_axis_tready is high and the geometry unit is not busy.
// The entry offset is divided by the sector size in an 8-stage pipeline, 4 bits a stage.
// After reset or any configuration write, a serial geometry unit runs two 32-step divisions
// while s_axis_tready stays low; configuration is always taken.
// Reset is synchronous, active low, and loads the default floppy geometry.
module fat_cluster_chain_locator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fccl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fccl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] mode, [29:2] cluster, [61:30] raw_entry, rest zero
    input  logic [fccl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] fat_type, [33:2] sector, [45:34] byte_offset, [47:46] sector_count,
    // [75:48] entry_value, [76] out_of_range, [104:77] cluster_count, rest zero
    output logic [fccl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NSTG = fccl_pkg::DIV_STAGES;
    localparam int BSTG = fccl_pkg::BITS_PER_STAGE;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIVR = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_SUB  = 3'd4;
    localparam logic [2:0] ST_DIVC = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // Configuration registers.
    logic [12:0] r_bps;
    logic [7:0]  r_spc;
    logic [15:0] r_resv;
    logic [7:0]  r_copies;
    logic [15:0] r_root;
    logic [31:0] r_fatsz;
    logic [31:0] r_total;
    logic [31:0] r_voff;

    // Derived geometry.
    logic [12:0] r_bps_nz;
    logic [7:0]  r_spc_nz;
    logic [39:0] r_fats;
    logic [41:0] r_ovh;
    logic [32:0] r_cnt_p1;
    logic [1:0]  r_type;
    logic [27:0] r_mark;
    logic [27:0] r_cnt_sat;

    // Serial geometry unit.
    logic [2:0]  r_state;
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [12:0] r_srem;
    logic [12:0] r_dsr;
    logic [13:0] w_st;
    logic        w_sge;

    // Item pipeline.
    fccl_pkg::t_pipe r_pipe [0:NSTG];
    fccl_pkg::t_pipe n_pipe [0:NSTG];
    fccl_pkg::t_pipe w_tmp;
    logic [13:0]     w_t;
    logic            w_q;
    logic [31:0]     w_rel;
    logic [31:0]     w_off;
    logic [1:0]      w_mode;
    logic [27:0]     w_cl;

    logic                              r_out_vld;
    logic [fccl_pkg::OUT_TDATA_W-1:0]  r_out;
    logic [fccl_pkg::OUT_TDATA_W-1:0]  n_out;
    logic                              w_en;

    assign o_cfg_ready   = 1'b1;
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en && !r_busy;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    always_comb begin
        w_st  = {r_srem, r_quo[31]};
        w_sge = w_st >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps    <= fccl_pkg::RST_BPS;
            r_spc    <= fccl_pkg::RST_SPC;
            r_resv   <= fccl_pkg::RST_RESV;
            r_copies <= fccl_pkg::RST_COPIES;
            r_root   <= fccl_pkg::RST_ROOT;
            r_fatsz  <= fccl_pkg::RST_FATSZ;
            r_total  <= fccl_pkg::RST_TOTAL;
            r_voff   <= fccl_pkg::RST_VOFF;
            r_state  <= ST_MUL;
            r_busy   <= 1'b1;
            r_cnt    <= 5'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fccl_pkg::REG_BPS:    r_bps    <= i_cfg_data[12:0];
                fccl_pkg::REG_SPC:    r_spc    <= i_cfg_data[7:0];
                fccl_pkg::REG_RESV:   r_resv   <= i_cfg_data[15:0];
                fccl_pkg::REG_COPIES: r_copies <= i_cfg_data[7:0];
                fccl_pkg::REG_ROOT:   r_root   <= i_cfg_data[15:0];
                fccl_pkg::REG_FATSZ:  r_fatsz  <= i_cfg_data;
                fccl_pkg::REG_TOTAL:  r_total  <= i_cfg_data;
                fccl_pkg::REG_VOFF:   r_voff   <= i_cfg_data;
                default: ;
            endcase
            r_state <= ST_MUL;
            r_busy  <= 1'b1;
            r_cnt   <= 5'd0;
        end else begin
            unique case (r_state) inside
                ST_IDLE: ;
                ST_MUL: begin
                    r_bps_nz <= (r_bps == 13'd0) ? 13'd1 : r_bps;
                    r_spc_nz <= (r_spc == 8'd0) ? 8'd1 : r_spc;
                    r_fats   <= 40'(r_copies * r_fatsz);
                    // Ceiling division of the root directory bytes.
                    r_quo    <= 32'({r_root, 5'd0}) + 32'((r_bps == 13'd0) ? 13'd1 : r_bps)
                                - 32'd1;
                    r_dsr    <= (r_bps == 13'd0) ? 13'd1 : r_bps;
                    r_srem   <= 13'd0;
                    r_cnt    <= 5'd0;
                    r_state  <= ST_DIVR;
                end
                ST_DIVR, ST_DIVC: begin
                    r_srem <= w_sge ? 13'(w_st - {1'b0, r_dsr}) : w_st[12:0];
                    r_quo  <= {r_quo[30:0], w_sge};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= (r_state == ST_DIVR) ? ST_SUM : ST_FIN;
                    end
                end
                ST_SUM: begin
                    r_ovh   <= 42'(r_resv) + 42'(r_fats) + 42'(r_quo);
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_quo   <= (42'(r_total) > r_ovh) ? 32'(42'(r_total) - r_ovh) : 32'd0;
                    r_dsr   <= 13'(r_spc_nz);
                    r_srem  <= 13'd0;
                    r_cnt   <= 5'd0;
                    r_state <= ST_DIVC;
                end
                ST_FIN: begin
                    r_cnt_p1  <= 33'(r_quo) + 33'd1;
                    r_cnt_sat <= (r_quo > 32'(fccl_pkg::MASK28)) ? fccl_pkg::MASK28
                                                                : r_quo[27:0];
                    if (r_quo < fccl_pkg::LIM_FAT12) begin
                        r_type <= fccl_pkg::TYPE_FAT12;
                        r_mark <= fccl_pkg::MARK_FAT12;
                    end else if (r_quo < fccl_pkg::LIM_FAT16) begin
                        r_type <= fccl_pkg::TYPE_FAT16;
                        r_mark <= fccl_pkg::MARK_FAT16;
                    end else begin
                        r_type <= fccl_pkg::TYPE_FAT32;
                        r_mark <= fccl_pkg::MARK_FAT32;
                    end
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // Entry stage and divider stages.
    always_comb begin
        w_mode = s_axis_tdata[1:0];
        w_cl   = s_axis_tdata[29:2];
        case (r_type)
            fccl_pkg::TYPE_FAT12: w_off = 32'(w_cl) + 32'(w_cl[27:1]);
            fccl_pkg::TYPE_FAT16: w_off = {3'd0, w_cl, 1'b0};
            default:              w_off = {2'd0, w_cl, 2'b0};
        endcase
        n_pipe[0].vld     = s_axis_tvalid && s_axis_tready;
        n_pipe[0].mode    = w_mode;
        n_pipe[0].cluster = w_cl;
        n_pipe[0].raw     = s_axis_tdata[61:30];
        n_pipe[0].oor     = 33'(w_cl) > r_cnt_p1;
        n_pipe[0].prod    = 32'd0;
        n_pipe[0].dvd     = w_off;
        n_pipe[0].rem     = 13'd0;
        w_rel = 32'(r_pipe[0].cluster) - 32'd2;
        w_t   = 14'd0;
        w_q   = 1'b0;
        w_tmp = r_pipe[0];
        for (int k = 0; k < NSTG; k++) begin
            w_tmp = r_pipe[k];
            for (int b = 0; b < BSTG; b++) begin
                w_t = {w_tmp.rem, w_tmp.dvd[31]};
                w_q = w_t >= {1'b0, r_bps_nz};
                w_tmp.rem = w_q ? 13'(w_t - {1'b0, r_bps_nz}) : w_t[12:0];
                w_tmp.dvd = {w_tmp.dvd[30:0], w_q};
            end
            if (k == 0) begin
                w_tmp.prod = 32'(w_rel * r_spc_nz);
            end
            n_pipe[k+1] = w_tmp;
        end
    end

    // Result assembly.
    always_comb begin
        logic [31:0] v_sector;
        logic [11:0] v_boff;
        logic [1:0]  v_scnt;
        logic [27:0] v_entry;
        fccl_pkg::t_pipe v_p;
        v_p      = r_pipe[NSTG];
        v_sector = 32'd0;
        v_boff   = 12'd0;
        v_scnt   = 2'd0;
        v_entry  = v_p.oor ? r_mark : 28'd0;
        if (v_p.mode == fccl_pkg::MODE_LOCATE && !v_p.oor) begin
            v_sector = r_voff + 32'(r_resv) + v_p.dvd;
            v_boff   = v_p.rem[11:0] & fccl_pkg::MASK12;
            v_scnt   = (r_type == fccl_pkg::TYPE_FAT12) ? 2'd2 : 2'd1;
        end else if (v_p.mode == fccl_pkg::MODE_DECODE && !v_p.oor) begin
            case (r_type)
                fccl_pkg::TYPE_FAT12:
                    v_entry = v_p.cluster[0] ? 28'(v_p.raw[15:4]) : 28'(v_p.raw[11:0]);
                fccl_pkg::TYPE_FAT16: v_entry = 28'(v_p.raw[15:0]);
                default:              v_entry = v_p.raw[27:0];
            endcase
        end else if (v_p.mode == fccl_pkg::MODE_DATA) begin
            v_sector = v_p.prod + r_ovh[31:0];
        end
        n_out = {7'd0, r_cnt_sat, v_p.oor, v_entry, v_scnt, v_boff, v_sector, r_type};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTG; k++) begin
                r_pipe[k].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k <= NSTG; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
            r_out_vld <= r_pipe[NSTG].vld;
            r_out     <= n_out;
        end
    end

endmodule
